// File: sv/xdct_pkg.sv
// Shared types, constants and helpers of the XOR distance contact table.
// Used by the top level; depends on nothing.
package xdct_pkg;

	localparam int ID_WIDTH          = 128;
	localparam int HALF_ID_W         = 64;
	localparam int DEF_BUCKET_COUNT  = 128;
	localparam int DEF_BUCKET_SIZE   = 8;
	localparam int CHUNK_W           = 32;
	localparam int CHUNK_COUNT       = ID_WIDTH / CHUNK_W;
	localparam int CHUNK_IDX_W       = $clog2(CHUNK_COUNT);
	localparam int TOP_W             = $clog2(CHUNK_W);
	localparam int BIDX_W            = 7;
	localparam int OPCODE_W          = 2;
	localparam int STATUS_W          = 4;
	localparam int IN_DATA_W         = 200;
	localparam int OUT_DATA_W        = 80;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAN_MODE = 2'd2;

	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;

	localparam logic [31:0] IP_ALL_ONES  = 32'hFFFFFFFF;
	localparam logic [31:0] MASK_8       = 32'hFF000000;
	localparam logic [31:0] NET_LOOPBACK = 32'h7F000000;
	localparam logic [31:0] NET_TEN      = 32'h0A000000;
	localparam logic [31:0] MASK_12      = 32'hFFF00000;
	localparam logic [31:0] NET_172      = 32'hAC100000;
	localparam logic [31:0] MASK_16      = 32'hFFFF0000;
	localparam logic [31:0] NET_192      = 32'hC0A80000;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED       = 4'd0,
		ST_UPDATED     = 4'd1,
		ST_SELF        = 4'd2,
		ST_ZERO_ID     = 4'd3,
		ST_BAD_IP      = 4'd4,
		ST_PRIVATE_IP  = 4'd5,
		ST_FULL        = 4'd6,
		ST_REMOVED     = 4'd7,
		ST_REMOVE_MISS = 4'd8,
		ST_FOUND       = 4'd9,
		ST_FIND_MISS   = 4'd10
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_VRD,
		S_VCAP,
		S_LOOK,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [7:0]           version;
		logic [15:0]          tcp_port;
		logic [15:0]          udp_port;
		logic [31:0]          ip;
		logic [HALF_ID_W-1:0] id_low;
		logic [HALF_ID_W-1:0] id_high;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	function automatic logic [TOP_W-1:0] top_bit(input logic [CHUNK_W-1:0] v);
		logic [TOP_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			if (v[i]) begin
				pos = TOP_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

// File: sv/xdct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used by the top level for contact data and bucket valid rows.
module xdct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/xor_distance_contact_table.sv
// Top level of the XOR distance contact table: filter, distance scan, bucket lookup.
// Depends on xdct_pkg and xdct_ram.
// An accepted input word goes through the four-step leading-one scan of the distance,
// the valid-row read (S_VRD, S_VCAP), a read of the bucket's ways one per cycle from the
// contact RAM and S_FIN; no new word is taken until the result is registered. Reset
// clears the control registers, the sequencer and one init flag per bucket; a bucket whose
// flag is clear reads as empty, so no clearing pass runs and the block is ready at once.
module xor_distance_contact_table import xdct_pkg::*; #(
	parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
	parameter int BUCKET_SIZE  = DEF_BUCKET_SIZE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// id_high, id_low, ip_address, udp_port, tcp_port, proto_version
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic [OPCODE_W-1:0]   s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// bucket_index, found_ip, found_udp_port, found_tcp_port, found_version, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status
	output logic [STATUS_W-1:0]   m_tuser
);

	localparam int SLOTS = BUCKET_COUNT * BUCKET_SIZE;
	localparam int BW    = BUCKET_COUNT > 1 ? $clog2(BUCKET_COUNT) : 1;
	localparam int WW    = BUCKET_SIZE > 1 ? $clog2(BUCKET_SIZE) : 1;
	localparam int SW    = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam logic [BIDX_W:0]      LAST_BUCKET = (BIDX_W + 1)'(BUCKET_COUNT - 1);
	localparam logic [WW-1:0]        LAST_WAY    = WW'(BUCKET_SIZE - 1);
	localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK = CHUNK_IDX_W'(CHUNK_COUNT - 1);

	state_t state_q, state_d;

	logic [HALF_ID_W-1:0]   own_high_q, own_low_q;
	logic                   lan_q;

	logic [OPCODE_W-1:0]    op_q;
	slot_t                  item_q;
	logic                   filt_ok_q;
	status_t                filt_st_q;
	logic [ID_WIDTH-1:0]    dist_q;
	logic [CHUNK_IDX_W-1:0] cnt_q;
	logic                   found_q;
	logic [BW-1:0]          bkt_q;
	logic [BUCKET_SIZE-1:0] valid_row_q;
	logic [WW-1:0]          way_q;
	logic                   hit_q, free_q;
	logic [WW-1:0]          hit_way_q, free_way_q;
	slot_t                  hit_data_q;
	logic [BUCKET_COUNT-1:0] row_init_q;

	logic                   m_tvalid_q;
	logic [OUT_DATA_W-1:0]  m_tdata_q;
	logic [STATUS_W-1:0]    m_tuser_q;

	slot_t                  in_item;
	logic                   in_self, in_zero, in_bad_ip, in_private;
	logic                   in_ok;
	status_t                in_st;

	logic [CHUNK_W-1:0]     chunk;
	logic [BIDX_W:0]        cand, cand_clamped;

	logic                   fin_go, fin_fire;
	logic                   scan_en, look_en;
	logic [WW-1:0]          rd_way;
	logic [SW-1:0]          dram_raddr, dram_waddr;
	logic                   dram_we;
	logic [SLOT_W-1:0]      dram_rdata;
	slot_t                  rd_slot;
	logic                   rd_match;
	logic                   vram_we;
	logic [BUCKET_SIZE-1:0] vram_wdata, vram_rdata;
	logic                   ins_ok;
	status_t                out_st;
	logic                   show_data;

	// Input unpacking and contact filter.
	always_comb begin
		in_item.id_high  = s_tdata[63:0];
		in_item.id_low   = s_tdata[127:64];
		in_item.ip       = s_tdata[159:128];
		in_item.udp_port = s_tdata[175:160];
		in_item.tcp_port = s_tdata[191:176];
		in_item.version  = s_tdata[199:192];
		in_self    = (in_item.id_high == own_high_q) && (in_item.id_low == own_low_q);
		in_zero    = (in_item.id_high == '0) && (in_item.id_low == '0);
		in_bad_ip  = (in_item.ip == '0) || (in_item.ip == IP_ALL_ONES);
		in_private = ((in_item.ip & MASK_8) == NET_LOOPBACK) ||
			((in_item.ip & MASK_8) == NET_TEN) ||
			((in_item.ip & MASK_12) == NET_172) ||
			((in_item.ip & MASK_16) == NET_192);
		in_ok = 1'b0;
		in_st = ST_ADDED;
		priority if (in_self) begin
			in_st = ST_SELF;
		end else if (in_zero) begin
			in_st = ST_ZERO_ID;
		end else if (in_bad_ip) begin
			in_st = ST_BAD_IP;
		end else if (!lan_q && in_private) begin
			in_st = ST_PRIVATE_IP;
		end else begin
			in_ok = 1'b1;
		end
	end

	always_comb begin
		chunk = dist_q[ID_WIDTH-1 -: CHUNK_W];
		cand  = {1'b0, cnt_q, top_bit(chunk)};
		cand_clamped = (cand > LAST_BUCKET) ? LAST_BUCKET : cand;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (cnt_q == '0) begin
					state_d = S_VRD;
				end
			end
			S_VRD:  state_d = S_VCAP;
			S_VCAP: state_d = S_LOOK;
			S_LOOK: begin
				if (way_q == LAST_WAY) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready = (state_q == S_IDLE);
		scan_en  = (state_q == S_SCAN);
		look_en  = (state_q == S_LOOK);
		fin_go   = !m_tvalid_q || m_tready;
		fin_fire = (state_q == S_FIN) && fin_go;
		rd_way   = (look_en && (way_q != LAST_WAY)) ? WW'(way_q + 1'b1) : '0;
	end

	always_comb begin
		rd_slot  = slot_t'(dram_rdata);
		rd_match = valid_row_q[way_q] && (rd_slot.id_high == item_q.id_high) &&
			(rd_slot.id_low == item_q.id_low);
		dram_raddr = SW'(SW'(bkt_q) * SW'(BUCKET_SIZE) + SW'(rd_way));
		dram_waddr = SW'(SW'(bkt_q) * SW'(BUCKET_SIZE) + SW'(hit_q ? hit_way_q : free_way_q));
		ins_ok     = (op_q == OP_INSERT) && filt_ok_q;
		dram_we    = fin_fire && ins_ok && (hit_q || free_q);
		vram_we    = fin_fire && ((ins_ok && !hit_q && free_q) || ((op_q == OP_REMOVE) && hit_q));
		if (op_q == OP_INSERT) begin
			vram_wdata = valid_row_q | (BUCKET_SIZE'(1) << free_way_q);
		end else begin
			vram_wdata = valid_row_q & ~(BUCKET_SIZE'(1) << hit_way_q);
		end
	end

	always_comb begin
		show_data = 1'b0;
		unique case (op_q)
			OP_INSERT: begin
				if (!filt_ok_q) begin
					out_st = filt_st_q;
				end else if (hit_q) begin
					out_st = ST_UPDATED;
				end else if (free_q) begin
					out_st = ST_ADDED;
				end else begin
					out_st = ST_FULL;
				end
			end
			OP_REMOVE: out_st = hit_q ? ST_REMOVED : ST_REMOVE_MISS;
			default: begin
				out_st    = hit_q ? ST_FOUND : ST_FIND_MISS;
				show_data = hit_q;
			end
		endcase
	end

	xdct_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOTS)
	) u_contact_ram (
		.clk  (clk),
		.we   (dram_we),
		.waddr(dram_waddr),
		.wdata(SLOT_W'(item_q)),
		.raddr(dram_raddr),
		.rdata(dram_rdata)
	);

	xdct_ram #(
		.WIDTH(BUCKET_SIZE),
		.DEPTH(BUCKET_COUNT)
	) u_valid_ram (
		.clk  (clk),
		.we   (vram_we),
		.waddr(bkt_q),
		.wdata(vram_wdata),
		.raddr(bkt_q),
		.rdata(vram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_high_q <= '0;
			own_low_q  <= '0;
			lan_q      <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_OWN_HIGH) begin
				own_high_q <= cfg_data;
			end
			if (cfg_index == CFG_OWN_LOW) begin
				own_low_q <= cfg_data;
			end
			if (cfg_index == CFG_LAN_MODE) begin
				lan_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			found_q    <= 1'b0;
			way_q      <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			row_init_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (s_tready && s_tvalid) begin
				cnt_q   <= LAST_CHUNK;
				found_q <= 1'b0;
			end else if (scan_en) begin
				cnt_q <= cnt_q - 1'b1;
				if (chunk != '0) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == S_VCAP) begin
				way_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (look_en) begin
				way_q <= (way_q == LAST_WAY) ? way_q : WW'(way_q + 1'b1);
				if (rd_match) begin
					hit_q <= 1'b1;
				end
				if (!valid_row_q[way_q]) begin
					free_q <= 1'b1;
				end
			end
			if (vram_we) begin
				row_init_q[bkt_q] <= 1'b1;
			end
			if (fin_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_q      <= s_tuser;
			item_q    <= in_item;
			filt_ok_q <= in_ok;
			filt_st_q <= in_st;
			dist_q    <= {in_item.id_high ^ own_high_q, in_item.id_low ^ own_low_q};
			bkt_q     <= '0;
		end else if (scan_en) begin
			dist_q <= dist_q << CHUNK_W;
			if (!found_q && (chunk != '0)) begin
				bkt_q <= BW'(cand_clamped);
			end
		end
		if (state_q == S_VCAP) begin
			valid_row_q <= row_init_q[bkt_q] ? vram_rdata : '0;
		end
		if (look_en) begin
			if (rd_match && !hit_q) begin
				hit_way_q  <= way_q;
				hit_data_q <= rd_slot;
			end
			if (!valid_row_q[way_q] && !free_q) begin
				free_way_q <= way_q;
			end
		end
		if (fin_fire) begin
			m_tuser_q <= out_st;
			m_tdata_q <= {1'b0,
				show_data ? hit_data_q.version  : 8'd0,
				show_data ? hit_data_q.tcp_port : 16'd0,
				show_data ? hit_data_q.udp_port : 16'd0,
				show_data ? hit_data_q.ip       : 32'd0,
				BIDX_W'(bkt_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_way_range: assert property (@(posedge clk) disable iff (!arst_n)
		look_en |-> way_q <= LAST_WAY)
		else $error("way counter ran past the bucket");

	a_hit_free_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_q && free_q && (state_q == S_FIN)) |-> hit_way_q != free_way_q)
		else $error("a matching way was also taken as free");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire |=> m_tvalid_q)
		else $error("finished word did not reach the output register");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tready && s_tvalid) |=> (state_q == S_SCAN) && (cnt_q == LAST_CHUNK) && !found_q)
		else $error("distance scan did not start from the top chunk");

	a_new_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(vram_we && (op_q == OP_INSERT)) |-> !valid_row_q[free_way_q])
		else $error("insert claimed a way that was already in use");

endmodule
